[rtl/rpbb_pkg.sv]
// Shared constants, types and helpers of the rotated primitive bounding box unit.
package rpbb_pkg;

  localparam logic [2:0] KIND_SPHERE   = 3'd0;
  localparam logic [2:0] KIND_BOX      = 3'd1;
  localparam logic [2:0] KIND_CAPSULE  = 3'd2;
  localparam logic [2:0] KIND_CONE     = 3'd3;
  localparam logic [2:0] KIND_CYLINDER = 3'd4;
  localparam logic [2:0] KIND_TORUS    = 3'd5;
  localparam logic [2:0] KIND_VESICA   = 3'd6;

  localparam logic [1:0] CFG_KIND   = 2'd0;
  localparam logic [1:0] CFG_SMOOTH = 2'd1;

  localparam logic signed [15:0] QUAT_ONE = 16'sd16384;

  typedef struct packed {
    logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  } qprod_t;

  typedef logic [2:0][2:0][21:0] mat_t;

  typedef struct packed {
    logic [2:0][2:0][56:0] pa;
    logic [2:0][53:0]      pd;
    logic [2:0][31:0]      pos;
    logic signed [33:0]    c;
  } s3_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[rtl/rpbb_matrix.sv]
// Inverse rotation matrix in Q14 from the quaternion products.
module rpbb_matrix (
  input  rpbb_pkg::qprod_t p,
  output rpbb_pkg::mat_t   m
);
  import rpbb_pkg::*;

  localparam logic signed [35:0] ONE = 36'sd268435456;

  logic signed [35:0] r [3][3];

  function automatic logic [21:0] rnd14(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = v + 36'sd8192;
    return t[35:14];
  endfunction

  always_comb begin
    r[0][0] = ONE - ((36'(p.yy) + 36'(p.zz)) <<< 1);
    r[0][1] = (36'(p.xy) - 36'(p.wz)) <<< 1;
    r[0][2] = (36'(p.xz) + 36'(p.wy)) <<< 1;
    r[1][0] = (36'(p.xy) + 36'(p.wz)) <<< 1;
    r[1][1] = ONE - ((36'(p.xx) + 36'(p.zz)) <<< 1);
    r[1][2] = (36'(p.yz) - 36'(p.wx)) <<< 1;
    r[2][0] = (36'(p.xz) - 36'(p.wy)) <<< 1;
    r[2][1] = (36'(p.yz) + 36'(p.wx)) <<< 1;
    r[2][2] = ONE - ((36'(p.xx) + 36'(p.yy)) <<< 1);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = rnd14(r[j][i]);
      end
    end
  end

endmodule

[rtl/rpbb_finish.sv]
// Final stage: extent sums, capsule and cone terms, kind select and saturation.
module rpbb_finish (
  input  rpbb_pkg::s3_t   s,
  input  logic [2:0]      kind,
  output logic [2:0][31:0] ctr,
  output logic [2:0][31:0] half
);
  import rpbb_pkg::*;

  logic [59:0]        acc   [3];
  logic [59:0]        acc_r [3];
  logic signed [53:0] pe    [3];
  logic signed [53:0] po    [3];
  logic signed [39:0] e     [3];
  logic signed [38:0] off   [3];
  logic [39:0]        ae    [3];
  logic [40:0]        aer   [3];
  logic signed [41:0] ct    [3];
  logic signed [41:0] ctr1  [3];
  logic signed [43:0] ch    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]   = 60'(s.pa[i][0]) + 60'(s.pa[i][1]) + 60'(s.pa[i][2]);
      acc_r[i] = acc[i] + 60'd8192;
      pe[i]    = $signed(s.pd[i]) + 54'sd8192;
      po[i]    = $signed(s.pd[i]) + 54'sd16384;
      e[i]     = pe[i][53:14];
      off[i]   = po[i][53:15];
      ae[i]    = e[i][39] ? 40'(-e[i]) : 40'(e[i]);
      aer[i]   = 41'(ae[i]) + 41'd1;
      ct[i]    = (42'($signed(s.pos[i])) <<< 1) + 42'(e[i]);
      ctr1[i]  = ct[i] + 42'sd1;
      ch[i]    = $signed({4'b0, aer[i][40:1]}) + 44'(s.c);
      case (kind)
        KIND_CAPSULE: begin
          ctr[i]  = sat32(64'($signed(ctr1[i][41:1])));
          half[i] = sat32(64'(ch[i]));
        end
        KIND_CONE: begin
          ctr[i]  = sat32(64'($signed(s.pos[i])) + 64'(off[i]));
          half[i] = sat32($signed({18'b0, acc_r[i][59:14]}));
        end
        KIND_SPHERE, KIND_BOX, KIND_CYLINDER, KIND_TORUS, KIND_VESICA: begin
          ctr[i]  = s.pos[i];
          half[i] = sat32($signed({18'b0, acc_r[i][59:14]}));
        end
        default: begin
          ctr[i]  = s.pos[i];
          half[i] = '0;
        end
      endcase
    end
  end

endmodule

[rtl/rotated_primitive_bounding_box_unit.sv]
// Top level of the rotated primitive bounding box unit.
// Usage:
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 shape kind, 1 smoothing factor); write only while the unit is empty.
//   Input channel in_valid/in_ready carries one shape edit per transfer:
//   position, dimensions, rounding and a Q1.14 quaternion.
//   Output channel out_valid/out_ready carries the bounding box as a
//   centre and a half size, Q16.16, saturated.
// Timing:
//   Four register stages: quaternion products, rotation matrix and local
//   half size, magnitude products, then sums and saturation into the
//   output register. Throughput is one edit per cycle while the receiver
//   takes every result, set by the four-stage pipeline; a stall holds it.
// Flow control:
//   Each stage holds its item while the next one is full and stalled, so a
//   stalled receiver fills the pipeline and then drops in_ready; bubbles
//   are squeezed out.
// Reset:
//   rst empties every stage and clears both configuration registers.
module rotated_primitive_bounding_box_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] dim_x,
  input  logic signed [31:0] dim_y,
  input  logic signed [31:0] dim_z,
  input  logic signed [31:0] dim_round,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] center_x,
  output logic signed [31:0] center_y,
  output logic signed [31:0] center_z,
  output logic signed [31:0] half_x,
  output logic signed [31:0] half_y,
  output logic signed [31:0] half_z
);
  import rpbb_pkg::*;

  logic [2:0]  kind;
  logic [30:0] smooth;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1
  qprod_t             s1_p;
  logic signed [33:0] s1_h [3];
  logic [2:0][31:0]   s1_pos;
  logic signed [31:0] s1_dx, s1_dy;
  // stage 2
  mat_t               s2_m;
  logic [34:0]        s2_hm [3];
  logic [2:0][31:0]   s2_pos;
  logic signed [31:0] s2_dy;
  logic signed [33:0] s2_c;
  // stage 3
  s3_t                s3;
  // stage 4
  logic [2:0][31:0]   s4_ctr, s4_half;

  logic signed [15:0] qx, qy, qz, qw;
  qprod_t             p_next;
  logic signed [33:0] h_next [3];
  logic signed [33:0] dx34, dy34, dz34, dr34, dyr;
  mat_t               m_next;
  logic signed [34:0] mg35;
  logic signed [34:0] hs [3];
  s3_t                s3_next;
  logic [21:0]        am [3][3];
  logic [2:0][31:0]   ctr_next, half_next;

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind   <= KIND_SPHERE;
      smooth <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KIND:   kind   <= cfg_data[2:0];
        CFG_SMOOTH: smooth <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (kind == KIND_SPHERE) begin
      qx = '0; qy = '0; qz = '0; qw = QUAT_ONE;
    end else begin
      qx = quat_x; qy = quat_y; qz = quat_z; qw = quat_w;
    end
    p_next.xx = 32'(qx) * 32'(qx);
    p_next.yy = 32'(qy) * 32'(qy);
    p_next.zz = 32'(qz) * 32'(qz);
    p_next.xy = 32'(qx) * 32'(qy);
    p_next.xz = 32'(qx) * 32'(qz);
    p_next.yz = 32'(qy) * 32'(qz);
    p_next.wx = 32'(qw) * 32'(qx);
    p_next.wy = 32'(qw) * 32'(qy);
    p_next.wz = 32'(qw) * 32'(qz);
    dx34 = 34'(dim_x);
    dy34 = 34'(dim_y);
    dz34 = 34'(dim_z);
    dr34 = 34'(dim_round);
    dyr  = (dy34 + 34'sd1) >>> 1;
    case (kind)
      KIND_SPHERE:   begin h_next[0] = dx34; h_next[1] = dx34; h_next[2] = dx34; end
      KIND_BOX:      begin h_next[0] = dx34; h_next[1] = dy34; h_next[2] = dz34; end
      KIND_CONE:     begin h_next[0] = dx34; h_next[1] = dyr;  h_next[2] = dx34; end
      KIND_CYLINDER: begin h_next[0] = dx34; h_next[1] = dy34; h_next[2] = dx34; end
      KIND_TORUS: begin
        h_next[0] = dx34 + dy34; h_next[1] = dy34; h_next[2] = dx34 + dy34;
      end
      KIND_VESICA: begin
        h_next[0] = dx34 + dr34; h_next[1] = dy34 + dr34; h_next[2] = dx34 + dr34;
      end
      default:       begin h_next[0] = '0; h_next[1] = '0; h_next[2] = '0; end
    endcase
  end

  rpbb_matrix u_matrix (
    .p (s1_p),
    .m (m_next)
  );

  always_comb begin
    mg35 = $signed({3'b0, smooth, 1'b0});
    for (int j = 0; j < 3; j++) begin
      hs[j] = 35'(s1_h[j]) + mg35;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        am[i][j] = s2_m[i][j][21] ? 22'(-$signed(s2_m[i][j])) : s2_m[i][j];
        s3_next.pa[i][j] = 57'(am[i][j]) * 57'(s2_hm[j]);
      end
      s3_next.pd[i] = 54'($signed(s2_m[i][1])) * 54'(s2_dy);
    end
    s3_next.pos = s2_pos;
    s3_next.c   = s2_c;
  end

  rpbb_finish u_finish (
    .s    (s3),
    .kind (kind),
    .ctr  (ctr_next),
    .half (half_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_p   <= p_next;
      s1_h   <= h_next;
      s1_pos <= {pos_z, pos_y, pos_x};
      s1_dx  <= dim_x;
      s1_dy  <= dim_y;
    end
    if (rdy2 && v1) begin
      s2_m   <= m_next;
      for (int j = 0; j < 3; j++) begin
        s2_hm[j] <= hs[j][34] ? 35'(-hs[j]) : 35'(hs[j]);
      end
      s2_pos <= s1_pos;
      s2_dy  <= s1_dy;
      s2_c   <= 34'(s1_dx) + 34'($signed({2'b0, smooth, 1'b0}));
    end
    if (rdy3 && v2) begin
      s3 <= s3_next;
    end
    if (rdy4 && v3) begin
      s4_ctr  <= ctr_next;
      s4_half <= half_next;
    end
  end

  assign out_valid = v4;
  assign center_x  = s4_ctr[0];
  assign center_y  = s4_ctr[1];
  assign center_z  = s4_ctr[2];
  assign half_x    = s4_half[0];
  assign half_y    = s4_half[1];
  assign half_z    = s4_half[2];

`ifndef ASSERT_OFF
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> in_ready) else $error("in_ready low with empty first stage");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("output valid just after reset");
  a_hold_s3: assert property (@(posedge clk) disable iff (rst)
    (v3 && !rdy3) |=> (v3 && $stable(s3))) else $error("stage 3 lost its item");
`endif

endmodule
